// ----- src/lrfg_pkg.sv -----
// Shared constants, control/status types and the color wheel function.
`timescale 1ns / 1ps

package lrfg_pkg;

    localparam int MAX_LEDS = 64;
    localparam int IDX_W    = $clog2(MAX_LEDS);
    localparam int CNT_W    = IDX_W + 1;
    // dividend for x*255/n with x < MAX_LEDS
    localparam int DIV_W    = IDX_W + 8;
    localparam int DIV_CW   = $clog2(DIV_W);

    localparam logic [1:0] MODE_SOLID   = 2'd0;
    localparam logic [1:0] MODE_RAINBOW = 2'd1;
    localparam logic [1:0] MODE_FULL    = 2'd2;
    localparam logic [1:0] MODE_SPREAD  = 2'd3;

    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_LED_COUNT = 2'd1;
    localparam logic [1:0] REG_SOLID     = 2'd2;

    localparam logic [CNT_W-1:0] LED_COUNT_RST = CNT_W'(MAX_LEDS);

    localparam logic [7:0] WHEEL_SEG1 = 8'd85;
    localparam logic [7:0] WHEEL_SEG2 = 8'd170;
    localparam logic [7:0] WHEEL_MAX  = 8'd255;

    typedef struct packed {
        logic frame_start;
        logic mod_start;
        logic mod_load;
        logic pix_start;
        logic emit;
        logic advance;
        logic phase_update;
    } ctrl_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic spread;
        logic last;
        logic div_done;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // three segments: red up/green down, blue up/red down, green up/blue down
    function automatic rgb_t color_wheel(input logic [7:0] pos);
        rgb_t       c;
        logic [7:0] p;
        logic [7:0] p3;
        if (pos < WHEEL_SEG1)
        begin
            p = pos;
        end
        else if (pos < WHEEL_SEG2)
        begin
            p = pos - WHEEL_SEG1;
        end
        else
        begin
            p = pos - WHEEL_SEG2;
        end
        p3 = {p[6:0], 1'b0} + p;
        if (pos < WHEEL_SEG1)
        begin
            c.r = p3;
            c.g = WHEEL_MAX - p3;
            c.b = 8'd0;
        end
        else if (pos < WHEEL_SEG2)
        begin
            c.r = WHEEL_MAX - p3;
            c.g = 8'd0;
            c.b = p3;
        end
        else
        begin
            c.r = 8'd0;
            c.g = p3;
            c.b = WHEEL_MAX - p3;
        end
        return c;
    endfunction

endpackage

// ----- src/lrfg_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module lrfg_div
    import lrfg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient,
    output logic [CNT_W-1:0] remainder
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  rem_reg;

    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    diff;
    logic              ge;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign ge      = shifted >= {1'b0, divisor};
    assign diff    = shifted - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- src/lrfg_dp.sv -----
// Datapath: LED counters, phases, color select and output register.
`timescale 1ns / 1ps

module lrfg_dp
    import lrfg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctrl_cmd_t        cmd,
    output dp_status_t       sts,
    input  logic [1:0]       cfg_mode,
    input  logic [CNT_W-1:0] cfg_led_count,
    input  logic [23:0]      cfg_solid_color,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [IDX_W-1:0] pixel_index,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic             last_pixel
);

    logic [CNT_W-1:0] n_cfg;
    logic [CNT_W-1:0] n_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] x_reg;
    logic [7:0]       wp_reg;
    logic [CNT_W-1:0] sp_reg;
    logic             out_valid_reg;
    logic [IDX_W-1:0] pix_reg;
    rgb_t             rgb_reg;
    logic             last_reg;

    logic             div_done;
    logic [DIV_W-1:0] div_quo;
    logic [CNT_W-1:0] div_rem;
    logic [DIV_W-1:0] div_dividend;
    logic [DIV_W-1:0] x_ext;

    logic [8:0]       rb_sum;
    logic [7:0]       rb_pos;
    logic             last;
    logic             x_wrap;
    rgb_t             rgb_next;

    assign n_cfg = (cfg_led_count > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : cfg_led_count;

    assign last   = ({1'b0, idx_reg} + 1'b1) == n_reg;
    assign x_wrap = ({1'b0, x_reg} + 1'b1) == n_reg;

    // x*255 = (x << 8) - x
    assign x_ext        = DIV_W'(x_reg);
    assign div_dividend = cmd.mod_start ? DIV_W'(sp_reg) : ((x_ext << 8) - x_ext);

    lrfg_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.mod_start | cmd.pix_start),
        .dividend  (div_dividend),
        .divisor   (n_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // (i + phase) mod 255, sum stays below 2*255
    assign rb_sum = {3'b000, idx_reg} + {1'b0, wp_reg};
    assign rb_pos = (rb_sum >= {1'b0, WHEEL_MAX}) ? 8'(rb_sum - {1'b0, WHEEL_MAX})
                                                  : rb_sum[7:0];

    always_comb
    begin
        case (cfg_mode)
            MODE_SOLID:   rgb_next = cfg_solid_color;
            MODE_RAINBOW: rgb_next = color_wheel(rb_pos);
            MODE_FULL:    rgb_next = color_wheel(wp_reg);
            default:      rgb_next = color_wheel(div_quo[7:0]);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            idx_reg       <= '0;
            x_reg         <= '0;
            wp_reg        <= '0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.frame_start)
            begin
                n_reg   <= n_cfg;
                idx_reg <= '0;
                x_reg   <= '0;
            end
            if (cmd.mod_load)
            begin
                x_reg <= div_rem[IDX_W-1:0];
            end
            if (cmd.advance)
            begin
                idx_reg <= idx_reg + 1'b1;
                x_reg   <= x_wrap ? '0 : x_reg + 1'b1;
            end
            if (cmd.phase_update)
            begin
                if (cfg_mode == MODE_RAINBOW || cfg_mode == MODE_FULL)
                begin
                    wp_reg <= wp_reg + 1'b1;
                end
                else if (cfg_mode == MODE_SPREAD)
                begin
                    sp_reg <= (sp_reg < n_reg) ? sp_reg + 1'b1 : '0;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pix_reg  <= idx_reg;
            rgb_reg  <= rgb_next;
            last_reg <= last;
        end
    end

    assign sts.n_zero   = n_cfg == '0;
    assign sts.spread   = cfg_mode == MODE_SPREAD;
    assign sts.last     = last;
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign pixel_index = pix_reg;
    assign red         = rgb_reg.r;
    assign green       = rgb_reg.g;
    assign blue        = rgb_reg.b;
    assign last_pixel  = last_reg;

endmodule

// ----- src/lrfg_ctrl.sv -----
// Frame sequencer: walks the LEDs and drives the datapath commands.
`timescale 1ns / 1ps

module lrfg_ctrl
    import lrfg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       frame_tick,
    output logic       in_ready,
    input  dp_status_t sts,
    output ctrl_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_MODW  = 3'd2;
    localparam logic [2:0] S_CALC  = 3'd3;
    localparam logic [2:0] S_CALCW = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_UPD   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && frame_tick)
                begin
                    cmd.frame_start = 1'b1;
                    if (sts.n_zero)
                        state_next = S_UPD;
                    else if (sts.spread)
                        state_next = S_MOD;
                    else
                        state_next = S_EMIT;
                end
            end
            S_MOD:
            begin
                cmd.mod_start = 1'b1;
                state_next    = S_MODW;
            end
            S_MODW:
            begin
                if (sts.div_done)
                begin
                    cmd.mod_load = 1'b1;
                    state_next   = S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.pix_start = 1'b1;
                state_next    = S_CALCW;
            end
            S_CALCW:
            begin
                if (sts.div_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.advance = 1'b1;
                    if (sts.last)
                        state_next = S_UPD;
                    else if (sts.spread)
                        state_next = S_CALC;
                end
            end
            S_UPD:
            begin
                cmd.phase_update = 1'b1;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("pixel loaded while output register still full");

    a_div_spread: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pix_start || cmd.mod_start) |-> sts.spread)
        else $error("divider started outside spread mode");

    a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.frame_start |=> !in_ready)
        else $error("request taken while a frame is in progress");

    a_update_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.phase_update |=> !cmd.phase_update && in_ready)
        else $error("phase update not followed by idle");
`endif

endmodule

// ----- src/led_rainbow_frame_generator.sv -----
// Top level: APB registers, frame sequencer and pixel datapath.
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// --------  ------------------------  ------------------------------------------
// input     in_valid / in_ready       frame_tick
// output    out_valid / out_ready     pixel_index, red, green, blue, last_pixel
// config    psel/penable/pwrite       paddr, pwdata, prdata (pready tied high)
//
// Solid, rainbow and full modes: the sequencer emits pixels back to back,
// held only by output stalls. Spread mode: the 14-step restoring divider
// (one quotient bit per cycle) runs once for the phase and once per LED to
// form the wheel position. A zero LED count emits no pixel, only the phase update.
// Output stalls hold the sequencer in its emit state; no pixel is dropped.
// Reset restores mode 0, 64 LEDs, black, both phases zero; no clearing pass.

module led_rainbow_frame_generator
    import lrfg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // frame request
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             frame_tick,
    // pixel results
    output logic             out_valid,
    input  logic             out_ready,
    output logic [IDX_W-1:0] pixel_index,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic             last_pixel,
    // configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [1:0]       mode_reg;
    logic [CNT_W-1:0] led_count_reg;
    logic [23:0]      solid_color_reg;
    logic             apb_write;
    logic [1:0]       reg_sel;

    ctrl_cmd_t        cmd;
    dp_status_t       sts;

    // Registers are word aligned; the word index selects the register.
    assign pready    = 1'b1;
    assign reg_sel   = paddr[3:2];
    assign apb_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_SOLID;
            led_count_reg   <= LED_COUNT_RST;
            solid_color_reg <= '0;
        end
        else if (apb_write)
        begin
            unique case (reg_sel)
                REG_MODE:      mode_reg        <= pwdata[1:0];
                REG_LED_COUNT: led_count_reg   <= pwdata[CNT_W-1:0];
                REG_SOLID:     solid_color_reg <= pwdata[23:0];
                default:       ;   // unmapped word: ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_MODE:      prdata = 32'(mode_reg);
            REG_LED_COUNT: prdata = 32'(led_count_reg);
            REG_SOLID:     prdata = 32'(solid_color_reg);
            default:       prdata = '0;
        endcase
    end

    // Sequencer: takes one frame request at a time, steps through the LEDs.
    lrfg_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .frame_tick (frame_tick),
        .in_ready   (in_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Datapath: phases, LED index, divider and the output register.
    lrfg_dp u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_mode        (mode_reg),
        .cfg_led_count   (led_count_reg),
        .cfg_solid_color (solid_color_reg),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .pixel_index     (pixel_index),
        .red             (red),
        .green           (green),
        .blue            (blue),
        .last_pixel      (last_pixel)
    );

endmodule

// ----- tb/lrfg_pixel_checker.sv -----
// Pixel checker for the LED rainbow frame generator: register tracking, pixel prediction, compare.
`timescale 1ns / 1ps

module lrfg_pixel_checker
    import lrfg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic             frame_tick,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [IDX_W-1:0] pixel_index,
    input  logic [7:0]       red,
    input  logic [7:0]       green,
    input  logic [7:0]       blue,
    input  logic             last_pixel,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic             pready,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output int               pending,
    output int               mismatches
);

    typedef struct packed {
        logic [IDX_W-1:0] index;
        rgb_t             color;
        logic             last;
    } pixel_t;

    pixel_t      pixels_due[$];
    pixel_t      want;
    pixel_t      got;

    logic [1:0]  mode_r;
    logic [6:0]  count_r;
    logic [23:0] solid_r;
    logic [7:0]  hue_phase;
    logic [6:0]  spread_phase;

    // hue 0..255 split into thirds of 85 steps; 255 belongs to the last third
    function automatic rgb_t wheel_rgb(input int hue);
        rgb_t c;
        int   seg;
        int   ramp;
        seg = hue / 85;
        if (seg > 2)
        begin
            seg = 2;
        end
        ramp = (hue - seg * 85) * 3;
        case (seg)
            0:
            begin
                c.r = 8'(ramp);
                c.g = 8'(255 - ramp);
                c.b = 8'd0;
            end
            1:
            begin
                c.r = 8'(255 - ramp);
                c.g = 8'd0;
                c.b = 8'(ramp);
            end
            default:
            begin
                c.r = 8'd0;
                c.g = 8'(ramp);
                c.b = 8'(255 - ramp);
            end
        endcase
        return c;
    endfunction

    // queue the pixels of one frame request, then step the phases
    task automatic render_frame();
        int     n;
        pixel_t px;
        n = (count_r > MAX_LEDS) ? MAX_LEDS : int'(count_r);
        for (int i = 0; i < n; i++)
        begin
            case (mode_r)
                MODE_SOLID:   px.color = solid_r;
                MODE_RAINBOW: px.color = wheel_rgb((i + hue_phase) % 255);
                MODE_FULL:    px.color = wheel_rgb(hue_phase);
                default:      px.color = wheel_rgb(((i + spread_phase) % n) * 255 / n);
            endcase
            px.index = IDX_W'(i);
            px.last  = (i == n - 1);
            pixels_due.push_back(px);
        end
        if (mode_r == MODE_RAINBOW || mode_r == MODE_FULL)
        begin
            hue_phase = hue_phase + 8'd1;
        end
        else if (mode_r == MODE_SPREAD)
        begin
            spread_phase = (spread_phase < n) ? spread_phase + 7'd1 : 7'd0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_r       = MODE_SOLID;
            count_r      = LED_COUNT_RST;
            solid_r      = 24'd0;
            hue_phase    = 8'd0;
            spread_phase = 7'd0;
            pixels_due.delete();
            pending      = 0;
            mismatches   = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_MODE:      mode_r  = pwdata[1:0];
                    REG_LED_COUNT: count_r = pwdata[6:0];
                    REG_SOLID:     solid_r = pwdata[23:0];
                    default:       ;
                endcase
            end
            // results first: a pixel taken on this edge cannot belong to a request taken on it
            if (out_valid && out_ready)
            begin
                got.index = pixel_index;
                got.color = {red, green, blue};
                got.last  = last_pixel;
                if (pixels_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR %0t: unexpected pixel idx=%0d rgb=%06h last=%0b",
                                 $time, got.index, got.color, got.last);
                    end
                end
                else
                begin
                    want = pixels_due.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("ERROR %0t: expected idx=%0d rgb=%06h last=%0b",
                                     $time, want.index, want.color, want.last);
                            $display("ERROR %0t:   actual idx=%0d rgb=%06h last=%0b",
                                     $time, got.index, got.color, got.last);
                        end
                    end
                end
            end
            if (in_valid && in_ready && frame_tick)
            begin
                render_frame();
            end
            pending = pixels_due.size();
        end
    end

endmodule

// ----- tb/tb_led_rainbow_frame_generator.sv -----
// Testbench top for the LED rainbow frame generator: stimulus, register programming, verdict.
`timescale 1ns / 1ps

// Frame requests go in on the input channel; every accepted request with the
// tick set yields one pixel per LED on the output channel. The checker beside
// the block follows register writes on the APB port, predicts each frame and
// compares pixel by pixel. This module only drives traffic and reports.
//
// Flow:
//   - short directed run: reset values, tick-less request, solid extremes,
//     rainbow/full/spread, spread phase above a lowered count, spread phase
//     reaching the count, zero count, counts above the strip size, a write
//     to an address past the register map
//   - random phases: program registers while idle, then a burst of requests
//   - runs until enough requests went in
module tb_led_rainbow_frame_generator
    import lrfg_pkg::*;
();

    // address slot past the register map; writes there must be ignored
    localparam logic [1:0] REG_UNUSED = 2'd3;
    // worst case in flight with nothing owed: a spread frame with zero LEDs
    // or a request without a tick; both take well under this
    localparam int DRAIN_CYCLES = 120;
    localparam int RANDOM_REQUESTS = 250;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             in_valid   = 1'b0;
    logic             frame_tick = 1'b0;
    logic             out_ready  = 1'b0;
    logic             psel       = 1'b0;
    logic             penable    = 1'b0;
    logic             pwrite     = 1'b0;
    logic [3:0]       paddr      = 4'd0;
    logic [31:0]      pwdata     = 32'd0;
    logic             in_ready;
    logic             out_valid;
    logic [IDX_W-1:0] pixel_index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             last_pixel;
    logic [31:0]      prdata;
    logic             pready;

    int               pending;
    int               mismatches;

    // shadow of what was programmed, used only to shape the stimulus
    logic [1:0]       cur_mode  = MODE_SOLID;
    logic [6:0]       cur_count = LED_COUNT_RST;
    // no random idling on either side while set
    logic             calm      = 1'b0;
    int               sent      = 0;
    int               roll;
    int               burst;
    int               eff_count;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    led_rainbow_frame_generator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .frame_tick  (frame_tick),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last_pixel  (last_pixel),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    lrfg_pixel_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .frame_tick  (frame_tick),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last_pixel  (last_pixel),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pending     (pending),
        .mismatches  (mismatches)
    );

    // receiver stalls about 37% of cycles, except inside the calm window
    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 37);
    end

    // APB write: setup cycle, access cycle, then an idle wait with psel low so that
    // back-to-back writes never touch psel twice in one step
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // unused upper bits carry noise; the block must mask them
    task automatic program_mode(input logic [1:0] m);
        cur_mode = m;
        write_reg(REG_MODE, {30'($urandom()), m});
    endtask

    task automatic program_count(input logic [6:0] c);
        cur_count = c;
        write_reg(REG_LED_COUNT, {25'($urandom()), c});
    endtask

    // one request; random idle cycles ahead of it unless calm
    task automatic send_request(input logic tick);
        while (!calm && $urandom_range(99) < 37)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        frame_tick <= tick;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
    endtask

    // hold off until every predicted pixel came back, then let the
    // sequencer finish anything that owes no pixel
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: solid black over 64 LEDs; a tick-less request does nothing
        send_request(1'b1);
        send_request(1'b0);
        settle();

        // solid extremes: single LED in white, then a mixed color
        program_count(7'd1);
        write_reg(REG_SOLID, 32'hFFFF_FFFF);
        send_request(1'b1);
        settle();
        program_count(7'd3);
        write_reg(REG_SOLID, 32'h005A_A53C);
        send_request(1'b1);
        settle();

        // rainbow over the full strip, full-strip wheel on two LEDs
        program_mode(MODE_RAINBOW);
        program_count(7'd64);
        repeat (2) send_request(1'b1);
        settle();
        program_mode(MODE_FULL);
        program_count(7'd2);
        repeat (2) send_request(1'b1);
        settle();

        // spread: climb the phase, then lower the count below it
        program_mode(MODE_SPREAD);
        program_count(7'd8);
        repeat (5) send_request(1'b1);
        settle();
        program_count(7'd3);
        send_request(1'b1);
        settle();
        // phase walks up to the count and wraps back to zero
        program_count(7'd2);
        repeat (3) send_request(1'b1);
        settle();

        // zero count: nothing out, phase still updates
        program_count(7'd0);
        send_request(1'b1);
        settle();
        program_mode(MODE_SOLID);
        send_request(1'b1);
        settle();

        // counts above the strip size clamp to it
        program_mode(MODE_RAINBOW);
        program_count(7'd100);
        send_request(1'b1);
        settle();
        program_mode(MODE_SPREAD);
        program_count(7'd127);
        write_reg(REG_UNUSED, $urandom());
        send_request(1'b1);
        settle();

        // random phases
        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            roll = $urandom_range(99);
            if (roll < 10)
                program_mode(MODE_SOLID);
            else if (roll < 50)
                program_mode(MODE_RAINBOW);
            else if (roll < 85)
                program_mode(MODE_FULL);
            else
                program_mode(MODE_SPREAD);

            if ($urandom_range(99) < 75)
            begin
                roll = $urandom_range(99);
                // mostly short strips keep the run fast; a few large and out-of-range
                if (roll < 55)
                    program_count(7'($urandom_range(8, 1)));
                else if (roll < 80)
                    program_count(7'($urandom_range(32, 9)));
                else if (roll < 92)
                    program_count(7'($urandom_range(64, 33)));
                else if (roll < 96)
                    program_count(7'd0);
                else
                    program_count(7'($urandom_range(127, 65)));
            end
            if ($urandom_range(99) < 40)
            begin
                write_reg(REG_SOLID, $urandom());
            end
            if ($urandom_range(99) < 5)
            begin
                write_reg(REG_UNUSED, $urandom());
            end

            eff_count = (cur_count > MAX_LEDS) ? MAX_LEDS : int'(cur_count);
            // spread frames on long strips are slow; keep those bursts short
            if (cur_mode == MODE_SPREAD && eff_count > 16)
                burst = $urandom_range(2, 1);
            else
                burst = $urandom_range(10, 2);

            repeat (burst)
            begin
                calm = (sent >= 120 && sent < 170);
                send_request($urandom_range(99) < 90);
            end
            settle();
        end

        calm = 1'b0;
        if (mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // hard stop: a stuck handshake or pixels that never arrive
    initial
    begin
        #50_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
src/lrfg_pkg.sv
src/lrfg_div.sv
src/lrfg_dp.sv
src/lrfg_ctrl.sv
src/led_rainbow_frame_generator.sv
tb/lrfg_pixel_checker.sv
tb/tb_led_rainbow_frame_generator.sv
